>>> src/dpp_pkg.sv
`timescale 1ns / 1ps
package dpp_pkg;

    // Field and register widths
    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int PIX_W          = 12;
    localparam int DEPTH_W        = 8;
    localparam int COLOR_W        = 8;
    localparam int PT_W           = 32;

    localparam logic [CFG_W-1:0] FOCAL_X_RST     = 24'd134400;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST     = 24'd134400;
    localparam logic [CFG_W-1:0] CENTER_X_RST    = 24'd81920;
    localparam logic [CFG_W-1:0] CENTER_Y_RST    = 24'd61440;
    localparam logic [CFG_W-1:0] RANGE_SCALE_RST = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X     = 3'd0,
        CFG_FOCAL_Y     = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_RANGE_SCALE = 3'd4
    } t_cfg_idx;

    // Depth codes that carry no measurement
    localparam logic [DEPTH_W-1:0] DEPTH_NONE_LO = 8'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_NONE_HI = 8'd255;

    // Range decode: x = ((9*d + 255) * scale + 255) / 510
    localparam int LIN_W       = 12;
    localparam int DEPTH_OFS   = 255;
    localparam int ROUND_OFS   = 255;
    localparam int RPROD_W     = LIN_W + CFG_W;
    localparam int M_W         = RPROD_W - 1;
    localparam int RSPLIT      = 18;
    localparam int PP_W        = 2 * RSPLIT;
    localparam int RECIP_W     = 36;
    // ceil(2^43 / 255); the dividend is halved first, so this divides by 510
    localparam logic [RECIP_W-1:0] RECIP = 36'd34494482441;
    localparam int RECIP_SHIFT = 43;
    localparam int SUM_W       = M_W + RECIP_W;
    localparam int X_W         = 27;

    // Projection and division
    localparam int MAG_W      = CFG_W;
    localparam int PROD_W     = MAG_W + X_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int QUO_W      = PT_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    localparam int FRONT_ST   = 3;
    localparam int PROJ_ST    = 2;
    localparam int NUM_STAGES = FRONT_ST + PROJ_ST + DIV_STAGES + 1;

    localparam logic [PT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [PT_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_row;
        logic [PIX_W-1:0]   pixel_col;
        logic [DEPTH_W-1:0] depth_code;
        logic [COLOR_W-1:0] color_blue;
        logic [COLOR_W-1:0] color_green;
        logic [COLOR_W-1:0] color_red;
    } t_pix_in;

    typedef struct packed {
        logic                   point_valid;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
        logic [COLOR_W-1:0]     point_red;
        logic [COLOR_W-1:0]     point_green;
        logic [COLOR_W-1:0]     point_blue;
    } t_point;

    typedef struct packed {
        logic               point_ok;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_pass;

    typedef struct packed {
        t_pass            pass;
        logic [X_W-1:0]   x;
    } t_tag;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_axis;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [CFG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div;

endpackage

>>> src/dpp_front.sv
`timescale 1ns / 1ps
module dpp_front #(
    parameter int COORD_BITS = dpp_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [dpp_pkg::FRONT_ST-1:0]  i_en,
    input  dpp_pkg::t_pix_in              i_pix,
    input  logic [dpp_pkg::CFG_W-1:0]     i_center_x,
    input  logic [dpp_pkg::CFG_W-1:0]     i_center_y,
    input  logic [dpp_pkg::CFG_W-1:0]     i_range_scale,
    output dpp_pkg::t_tag                 o_tag,
    output dpp_pkg::t_axis                o_axis_y,
    output dpp_pkg::t_axis                o_axis_z
);
    import dpp_pkg::*;

    logic [LIN_W-1:0]   depth_lin;
    logic [RPROD_W-1:0] n_prod;
    t_pass              n_pass;
    t_axis              n_axy;
    t_axis              n_axz;
    logic [RPROD_W-1:0] dividend;
    logic [M_W-1:0]     half;
    logic [PP_W-1:0]    n_pp0;
    logic [PP_W-1:0]    n_pp1;
    logic [PP_W-1:0]    n_pp2;
    logic [PP_W-1:0]    n_pp3;
    logic [SUM_W-1:0]   sum;

    logic [RPROD_W-1:0] r_prod;
    t_pass              r_pass1;
    t_axis              r_axy1;
    t_axis              r_axz1;
    logic [PP_W-1:0]    r_pp0;
    logic [PP_W-1:0]    r_pp1;
    logic [PP_W-1:0]    r_pp2;
    logic [PP_W-1:0]    r_pp3;
    t_pass              r_pass2;
    t_axis              r_axy2;
    t_axis              r_axz2;
    logic [X_W-1:0]     r_x3;
    t_pass              r_pass3;
    t_axis              r_axy3;
    t_axis              r_axz3;

    // Signed offset of the pixel from the principal point in Q.8; the result
    // coordinate is negative when the pixel lies beyond the center.
    function automatic t_axis axis_prep(logic [PIX_W-1:0] pix, logic [CFG_W-1:0] center);
        logic [PIX_W-1:0] used;
        logic [CFG_W:0]   pix_q8;
        logic [CFG_W:0]   diff;
        t_axis            res;
        used     = pix & PIX_W'((1 << COORD_BITS) - 1);
        pix_q8   = (CFG_W+1)'({used, 8'h00});
        diff     = pix_q8 - {1'b0, center};
        res.neg  = !diff[CFG_W] && (diff != '0);
        res.mag  = diff[CFG_W] ? MAG_W'(-diff) : MAG_W'(diff);
        return res;
    endfunction

    // Stage 1: linear depth term times the range scale
    always_comb begin
        depth_lin = {1'b0, i_pix.depth_code, 3'b000} + {4'h0, i_pix.depth_code}
                  + LIN_W'(DEPTH_OFS);
        n_prod    = RPROD_W'(depth_lin) * RPROD_W'(i_range_scale);
        n_pass.point_ok = (i_pix.depth_code != DEPTH_NONE_LO)
                       && (i_pix.depth_code != DEPTH_NONE_HI);
        n_pass.red   = i_pix.color_red;
        n_pass.green = i_pix.color_green;
        n_pass.blue  = i_pix.color_blue;
        n_axy = axis_prep(i_pix.pixel_col, i_center_x);
        n_axz = axis_prep(i_pix.pixel_row, i_center_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod  <= n_prod;
            r_pass1 <= n_pass;
            r_axy1  <= n_axy;
            r_axz1  <= n_axz;
        end
    end

    // Stage 2: partial products of the reciprocal multiply
    always_comb begin
        dividend = r_prod + RPROD_W'(ROUND_OFS);
        half     = dividend[RPROD_W-1:1];
        n_pp0 = PP_W'(half[RSPLIT-1:0]) * PP_W'(RECIP[RSPLIT-1:0]);
        n_pp1 = PP_W'(half[RSPLIT-1:0]) * PP_W'(RECIP[RECIP_W-1:RSPLIT]);
        n_pp2 = PP_W'(half[M_W-1:RSPLIT]) * PP_W'(RECIP[RSPLIT-1:0]);
        n_pp3 = PP_W'(half[M_W-1:RSPLIT]) * PP_W'(RECIP[RECIP_W-1:RSPLIT]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pp0   <= n_pp0;
            r_pp1   <= n_pp1;
            r_pp2   <= n_pp2;
            r_pp3   <= n_pp3;
            r_pass2 <= r_pass1;
            r_axy2  <= r_axy1;
            r_axz2  <= r_axz1;
        end
    end

    // Stage 3: combine partial products; the quotient always fits X_W bits.
    assign sum = SUM_W'(r_pp0) + (SUM_W'(r_pp1) << RSPLIT) + (SUM_W'(r_pp2) << RSPLIT)
               + (SUM_W'(r_pp3) << (2 * RSPLIT));

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_x3    <= sum[RECIP_SHIFT +: X_W];
            r_pass3 <= r_pass2;
            r_axy3  <= r_axy2;
            r_axz3  <= r_axz2;
        end
    end

    assign o_tag.pass = r_pass3;
    assign o_tag.x    = r_x3;
    assign o_axis_y   = r_axy3;
    assign o_axis_z   = r_axz3;

endmodule

>>> src/dpp_proj.sv
`timescale 1ns / 1ps
module dpp_proj (
    input  logic                         i_clk,
    input  logic [dpp_pkg::PROJ_ST-1:0]  i_en,
    input  dpp_pkg::t_axis               i_axis,
    input  logic [dpp_pkg::X_W-1:0]      i_x,
    input  logic [dpp_pkg::CFG_W-1:0]    i_div,
    output dpp_pkg::t_div                o_div
);
    import dpp_pkg::*;

    logic [PROD_W-1:0] n_prod;
    logic [NUM_W-1:0]  num;
    t_div              n_out;

    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    t_div              r_out;

    assign n_prod = PROD_W'(i_axis.mag) * PROD_W'(i_x);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= n_prod;
            r_neg  <= i_axis.neg;
        end
    end

    // Add half the divisor for round-to-nearest. The upper part of the
    // dividend is the first partial remainder; if it already reaches the
    // divisor the quotient needs more than 32 bits and will saturate.
    always_comb begin
        num       = NUM_W'(r_prod) + NUM_W'(i_div >> 1);
        n_out.neg = r_neg;
        n_out.rem = CFG_W'(num[NUM_W-1:QUO_W]);
        n_out.ovf = n_out.rem >= i_div;
        n_out.quo = num[QUO_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_div = r_out;

endmodule

>>> src/dpp_div_stage.sv
`timescale 1ns / 1ps
module dpp_div_stage (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [dpp_pkg::CFG_W-1:0]  i_div,
    input  dpp_pkg::t_div              i_in,
    output dpp_pkg::t_div              o_out
);
    import dpp_pkg::*;

    t_div           work;
    logic [CFG_W:0] trial;
    logic           ge;
    t_div           r_out;

    // Restoring division: the dividend bits shift out of the top of quo
    // while quotient bits shift in at the bottom.
    always_comb begin
        work  = i_in;
        trial = '0;
        ge    = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            trial    = {work.rem, work.quo[QUO_W-1]};
            ge       = trial >= {1'b0, i_div};
            work.rem = ge ? CFG_W'(trial - {1'b0, i_div}) : trial[CFG_W-1:0];
            work.quo = {work.quo[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= work;
        end
    end

    assign o_out = r_out;

endmodule

>>> src/depth_pixel_to_point.sv
`timescale 1ns / 1ps
// Channel   Dir   Handshake                    Payload
// pixel     in    i_pix_valid / o_pix_stall    i_pix (t_pix_in)
// point     out   o_pt_valid  / i_pt_stall     o_pt (t_point)
// config    in    i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One pixel is taken per clock while o_pix_stall is low. Each result passes 3 + 2 + 8 + 1 = 14
// register stages: range decode, projection multiply, eight stages that each resolve four bits
// of the 32-bit lateral and vertical quotients, and the output register.
// Reset (synchronous, active low) empties the pipeline and loads the default camera model.
// A stall on the point side holds only full stages; empty slots close up, and the pixel
// side is stalled only while every stage holds an item.
module depth_pixel_to_point #(
    parameter int COORD_BITS = dpp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pix_valid,
    output logic                            o_pix_stall,
    input  dpp_pkg::t_pix_in                i_pix,
    output logic                            o_pt_valid,
    input  logic                            i_pt_stall,
    output dpp_pkg::t_point                 o_pt,
    input  logic                            i_cfg_we,
    input  logic [dpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dpp_pkg::CFG_W-1:0]       i_cfg_data
);
    import dpp_pkg::*;

    localparam int TAG_N = PROJ_ST + DIV_STAGES;

    logic [CFG_W-1:0]      r_focal_x;
    logic [CFG_W-1:0]      r_focal_y;
    logic [CFG_W-1:0]      r_center_x;
    logic [CFG_W-1:0]      r_center_y;
    logic [CFG_W-1:0]      r_range_scale;
    logic [NUM_STAGES-1:0] r_valid;
    t_tag                  r_tag [TAG_N];
    t_point                r_out;
    t_point                n_out;

    logic [NUM_STAGES-1:0] stage_en;
    logic [CFG_W-1:0]      div_x;
    logic [CFG_W-1:0]      div_y;
    t_tag                  front_tag;
    t_axis                 axis_y;
    t_axis                 axis_z;
    t_div                  chain_y [DIV_STAGES+1];
    t_div                  chain_z [DIV_STAGES+1];

    function automatic logic signed [PT_W-1:0] sat_coord(t_div d);
        logic [PT_W-1:0] res;
        if (d.neg) begin
            if (d.ovf || (d.quo[QUO_W-1] && (d.quo[QUO_W-2:0] != '0))) begin
                res = SAT_MIN;
            end else begin
                res = ~d.quo + 1'b1;
            end
        end else begin
            if (d.ovf || d.quo[QUO_W-1]) begin
                res = SAT_MAX;
            end else begin
                res = d.quo;
            end
        end
        return $signed(res);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x     <= FOCAL_X_RST;
            r_focal_y     <= FOCAL_Y_RST;
            r_center_x    <= CENTER_X_RST;
            r_center_y    <= CENTER_Y_RST;
            r_range_scale <= RANGE_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL_X:     r_focal_x     <= i_cfg_data;
                CFG_FOCAL_Y:     r_focal_y     <= i_cfg_data;
                CFG_CENTER_X:    r_center_x    <= i_cfg_data;
                CFG_CENTER_Y:    r_center_y    <= i_cfg_data;
                CFG_RANGE_SCALE: r_range_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero focal length divides as one.
    assign div_x = (r_focal_x == '0) ? CFG_W'(1) : r_focal_x;
    assign div_y = (r_focal_y == '0) ? CFG_W'(1) : r_focal_y;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb begin
        stage_en[NUM_STAGES-1] = ~r_valid[NUM_STAGES-1] | ~i_pt_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = ~r_valid[k] | stage_en[k+1];
        end
    end

    assign o_pix_stall = ~stage_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_pix_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    dpp_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_en          (stage_en[FRONT_ST-1:0]),
        .i_pix         (i_pix),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .i_range_scale (r_range_scale),
        .o_tag         (front_tag),
        .o_axis_y      (axis_y),
        .o_axis_z      (axis_z)
    );

    dpp_proj u_proj_y (
        .i_clk  (i_clk),
        .i_en   (stage_en[FRONT_ST +: PROJ_ST]),
        .i_axis (axis_y),
        .i_x    (front_tag.x),
        .i_div  (div_x),
        .o_div  (chain_y[0])
    );

    dpp_proj u_proj_z (
        .i_clk  (i_clk),
        .i_en   (stage_en[FRONT_ST +: PROJ_ST]),
        .i_axis (axis_z),
        .i_x    (front_tag.x),
        .i_div  (div_y),
        .o_div  (chain_z[0])
    );

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        dpp_div_stage u_div_y (
            .i_clk (i_clk),
            .i_en  (stage_en[FRONT_ST + PROJ_ST + j]),
            .i_div (div_x),
            .i_in  (chain_y[j]),
            .o_out (chain_y[j+1])
        );
        dpp_div_stage u_div_z (
            .i_clk (i_clk),
            .i_en  (stage_en[FRONT_ST + PROJ_ST + j]),
            .i_div (div_y),
            .i_in  (chain_z[j]),
            .o_out (chain_z[j+1])
        );
    end

    // Color, range and the skip flag ride alongside the projection and division stages.
    always_ff @(posedge i_clk) begin
        if (stage_en[FRONT_ST]) begin
            r_tag[0] <= front_tag;
        end
        for (int j = 1; j < TAG_N; j++) begin
            if (stage_en[FRONT_ST + j]) begin
                r_tag[j] <= r_tag[j-1];
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (r_tag[TAG_N-1].pass.point_ok) begin
            n_out.point_valid = 1'b1;
            n_out.point_x     = $signed(PT_W'(r_tag[TAG_N-1].x));
            n_out.point_y     = sat_coord(chain_y[DIV_STAGES]);
            n_out.point_z     = sat_coord(chain_z[DIV_STAGES]);
            n_out.point_red   = r_tag[TAG_N-1].pass.red;
            n_out.point_green = r_tag[TAG_N-1].pass.green;
            n_out.point_blue  = r_tag[TAG_N-1].pass.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[NUM_STAGES-1]) begin
            r_out <= n_out;
        end
    end

    assign o_pt_valid = r_valid[NUM_STAGES-1];
    assign o_pt       = r_out;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_stall |-> ((&r_valid) && i_pt_stall))
        else $error("pixel side stalled while the pipeline has room");

    a_fill_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NUM_STAGES-2] && !o_pt_valid) |=> o_pt_valid)
        else $error("item ahead of an empty output register was not moved");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt_valid && !o_pt.point_valid) |->
            (o_pt.point_x == '0 && o_pt.point_y == '0 && o_pt.point_z == '0
             && o_pt.point_red == '0 && o_pt.point_green == '0 && o_pt.point_blue == '0))
        else $error("skipped pixel carries nonzero fields");

    a_forward_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt_valid |-> !o_pt.point_x[PT_W-1])
        else $error("forward coordinate went negative");

endmodule

>>> tb/sv/tb_depth_pixel_to_point.sv
`timescale 1ns / 1ps
module tb_depth_pixel_to_point;
    import dpp_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = NUM_STAGES + 4;
    localparam int MAX_REPORTS    = 40;
    localparam int COORD_MAX      = (1 << PIX_W) - 1;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             pix_valid;
    logic             pix_stall;
    t_pix_in          pix;
    logic             pt_valid;
    logic             pt_stall;
    t_point           pt;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    // Camera model as the block should hold it.
    logic [CFG_W-1:0] cam_fx;
    logic [CFG_W-1:0] cam_fy;
    logic [CFG_W-1:0] cam_cx;
    logic [CFG_W-1:0] cam_cy;
    logic [CFG_W-1:0] cam_scale;

    t_point points_due[$];
    int     mismatches = 0;
    int     quiet_cycles = 0;
    bit     steady = 1'b0;
    int     hold_requests = 0;

    depth_pixel_to_point dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix_valid (pix_valid),
        .o_pix_stall (pix_stall),
        .i_pix       (pix),
        .o_pt_valid  (pt_valid),
        .i_pt_stall  (pt_stall),
        .o_pt        (pt),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // One lateral or vertical coordinate: -(pix - center) * x / focal, rounded
    // half away from zero on the magnitude and saturated to 32 bits.
    function automatic logic [PT_W-1:0] project_coord(input logic [PIX_W-1:0] pix_idx,
                                                      input logic [CFG_W-1:0] center,
                                                      input logic [CFG_W-1:0] focal,
                                                      input logic [63:0] range_q16);
        logic [PIX_W-1:0] used;
        longint           diff;
        logic [63:0]      mag;
        logic [63:0]      div;
        logic [63:0]      quo;
        logic [63:0]      neg;
        used = pix_idx & PIX_W'((1 << COORD_BITS_DEF) - 1);
        diff = longint'({used, 8'd0}) - longint'(center);
        mag  = (diff < 0) ? -diff : diff;
        div  = (focal == '0) ? 64'd1 : 64'(focal);
        quo  = (mag * range_q16 + div / 2) / div;
        if (diff > 0) begin
            if (quo > 64'd2147483648)
                return SAT_MIN;
            neg = -quo;
            return neg[PT_W-1:0];
        end
        if (quo > 64'd2147483647)
            return SAT_MAX;
        return quo[PT_W-1:0];
    endfunction

    function automatic t_point predict_point(input t_pix_in p);
        t_point      res;
        logic [63:0] range_q16;
        res = '0;
        if (p.depth_code == DEPTH_NONE_LO || p.depth_code == DEPTH_NONE_HI)
            return res;
        range_q16 = ((64'd9 * p.depth_code + 64'd255) * cam_scale + 64'd255) / 64'd510;
        res.point_valid = 1'b1;
        res.point_x     = range_q16[PT_W-1:0];
        res.point_y     = project_coord(p.pixel_col, cam_cx, cam_fx, range_q16);
        res.point_z     = project_coord(p.pixel_row, cam_cy, cam_fy, range_q16);
        res.point_red   = p.color_red;
        res.point_green = p.color_green;
        res.point_blue  = p.color_blue;
        return res;
    endfunction

    function automatic t_pix_in make_pixel(input int row, input int col, input int depth,
                                           input int blue, input int green, input int red);
        t_pix_in p;
        p.pixel_row   = PIX_W'(row);
        p.pixel_col   = PIX_W'(col);
        p.depth_code  = DEPTH_W'(depth);
        p.color_blue  = COLOR_W'(blue);
        p.color_green = COLOR_W'(green);
        p.color_red   = COLOR_W'(red);
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] rand_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return PIX_W'(COORD_MAX);
        return PIX_W'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        int      roll;
        p.pixel_row = rand_coord();
        p.pixel_col = rand_coord();
        roll = $urandom_range(0, 99);
        if (roll < 5)
            p.depth_code = DEPTH_NONE_LO;
        else if (roll < 10)
            p.depth_code = DEPTH_NONE_HI;
        else
            p.depth_code = DEPTH_W'($urandom_range(1, 254));
        p.color_blue  = COLOR_W'($urandom);
        p.color_green = COLOR_W'($urandom);
        p.color_red   = COLOR_W'($urandom);
        return p;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // The expected point is queued at the edge where the pixel transfer happens.
    task automatic send_pixel(input t_pix_in p);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            pix_valid = 1'b0;
        end
        @(negedge clk);
        pix_valid = 1'b1;
        pix       = p;
        do @(posedge clk); while (pix_stall);
        points_due = {points_due, predict_point(p)};
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pix_valid = 1'b0;
        while (points_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        case (idx)
            CFG_FOCAL_X:     cam_fx    = value;
            CFG_FOCAL_Y:     cam_fy    = value;
            CFG_CENTER_X:    cam_cx    = value;
            CFG_CENTER_Y:    cam_cy    = value;
            CFG_RANGE_SCALE: cam_scale = value;
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [CFG_W-1:0] fx, input logic [CFG_W-1:0] fy,
                              input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                              input logic [CFG_W-1:0] scale);
        wait_drained();
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RANGE_SCALE, scale);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Default camera: center at column 320, row 240, focal length 525.
    task automatic test_directed_pixels();
        send_pixel(make_pixel(0, 0, 1, 0, 0, 0));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 254, 255, 255, 255));
        send_pixel(make_pixel(240, 320, 128, 1, 2, 3));
        send_pixel(make_pixel(100, 100, DEPTH_NONE_LO, 200, 150, 100));
        send_pixel(make_pixel(COORD_MAX, 0, DEPTH_NONE_HI, 255, 255, 255));
        send_pixel(make_pixel(0, COORD_MAX, 200, 8'hAA, 8'h55, 8'h0F));
        send_pixel(make_pixel(COORD_MAX, 0, 50, 8'h55, 8'hAA, 8'hF0));
        send_pixel(make_pixel(241, 319, 2, 17, 34, 51));
        send_pixel(make_pixel(239, 321, 253, 68, 85, 102));
        send_pixel(make_pixel(1, 1, 127, 128, 127, 129));
        send_pixel(make_pixel(2048, 2048, 254, 0, 255, 0));
    endtask

    // Zero focal length acts as one; focal lengths of zero and one drive both saturation limits.
    task automatic test_camera_extremes();
        set_camera('0, '0, '0, '0, CFG_MAX);
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 254, 1, 2, 3));
        send_random(30);
        set_camera(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, '0);
        send_random(30);
        set_camera(CFG_W'(1), CFG_W'(1), CFG_MAX, CFG_MAX, CFG_MAX);
        send_pixel(make_pixel(0, 0, 254, 4, 5, 6));
        send_random(30);
        set_camera(CFG_MAX, CFG_MAX, '0, '0, CFG_MAX);
        send_random(30);
        set_camera(CFG_W'(1), CFG_MAX, '0, CFG_MAX, CFG_W'(1));
        send_random(30);
    endtask

    task automatic test_random_cameras();
        repeat (13) begin
            if ($urandom_range(0, 99) < 25)
                set_camera(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                           CFG_W'($urandom), CFG_W'($urandom));
            else
                set_camera(CFG_W'($urandom_range(100 * 256, 2000 * 256)),
                           CFG_W'($urandom_range(100 * 256, 2000 * 256)),
                           CFG_W'($urandom_range(0, COORD_MAX * 256)),
                           CFG_W'($urandom_range(0, COORD_MAX * 256)),
                           CFG_W'($urandom_range(1 << 15, 1 << 18)));
            send_random(70);
        end
    endtask

    // The output side holds off long enough for every stage to fill, so the
    // pixel side has to stall while new pixels keep being offered.
    task automatic test_output_holdoff();
        set_camera(FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST, RANGE_SCALE_RST);
        steady = 1'b1;
        hold_requests++;
        send_random(80);
        steady = 1'b0;
    endtask

    task automatic test_steady_stream();
        wait_drained();
        steady = 1'b1;
        send_random(120);
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_random(40);
        wait_drained();
        send_random(40);
    endtask

    // Output stall: random bursts, a long hold on request, no new random bursts while steady.
    initial begin : sink_stall
        int burst_left;
        int hold_left;
        int hold_served;
        int roll;
        burst_left  = 0;
        hold_left   = 0;
        hold_served = 0;
        pt_stall    = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != hold_served && hold_left == 0) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                pt_stall = 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                pt_stall = 1'b1;
            end else if (steady) begin
                pt_stall = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    pt_stall = 1'b0;
                end else if (roll < 96) begin
                    burst_left = $urandom_range(0, 3);
                    pt_stall   = 1'b1;
                end else begin
                    burst_left = $urandom_range(10, 40);
                    pt_stall   = 1'b1;
                end
            end
        end
    end

    always @(posedge clk) begin : point_checker
        t_point want;
        if (rst_n && pt_valid && !pt_stall) begin
            if (points_due.size() == 0) begin
                report_mismatch("point with no pixel pending",
                                64'($unsigned(pt.point_x)), '0);
            end else begin
                want = points_due.pop_front();
                if (pt.point_valid !== want.point_valid)
                    report_mismatch("point_valid", 64'(pt.point_valid),
                                    64'(want.point_valid));
                if (pt.point_x !== want.point_x)
                    report_mismatch("point_x", 64'($unsigned(pt.point_x)),
                                    64'($unsigned(want.point_x)));
                if (pt.point_y !== want.point_y)
                    report_mismatch("point_y", 64'($unsigned(pt.point_y)),
                                    64'($unsigned(want.point_y)));
                if (pt.point_z !== want.point_z)
                    report_mismatch("point_z", 64'($unsigned(pt.point_z)),
                                    64'($unsigned(want.point_z)));
                if (pt.point_red !== want.point_red)
                    report_mismatch("point_red", 64'(pt.point_red), 64'(want.point_red));
                if (pt.point_green !== want.point_green)
                    report_mismatch("point_green", 64'(pt.point_green),
                                    64'(want.point_green));
                if (pt.point_blue !== want.point_blue)
                    report_mismatch("point_blue", 64'(pt.point_blue), 64'(want.point_blue));
            end
        end
    end

    always @(posedge clk) begin
        if ((pix_valid && !pix_stall) || (pt_valid && !pt_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix       = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_FOCAL_X;
        cfg_data  = '0;
        cam_fx    = FOCAL_X_RST;
        cam_fy    = FOCAL_Y_RST;
        cam_cx    = CENTER_X_RST;
        cam_cy    = CENTER_Y_RST;
        cam_scale = RANGE_SCALE_RST;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed_pixels();
        test_camera_extremes();
        test_random_cameras();
        test_output_holdoff();
        test_steady_stream();
        test_drain_pause();
        wait_drained();

        if (points_due.size() != 0)
            report_mismatch("points never produced", 64'(points_due.size()), '0);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
